// ===== rtl/core/fdr_pkg.sv =====
`timescale 1ns / 1ps

package fdr_pkg;

    localparam int NUM_PLANES   = 6;
    localparam int CORDIC_STEPS = 14;
    localparam int SWEEP_LAST   = NUM_PLANES + CORDIC_STEPS - 1;

    localparam logic signed [17:0] CORDIC_START = 18'sd9949;
    localparam logic signed [16:0] QUARTER      = 17'sd16384;
    localparam logic signed [16:0] HALF_TURN    = 17'sd32768;
    localparam logic signed [17:0] TRIG_MAX     = 18'sd16384;
    localparam logic signed [17:0] TRIG_MIN     = -18'sd16384;

    typedef enum logic [2:0] {
        REG_ANGLE_XY = 3'd0,
        REG_ANGLE_XZ = 3'd1,
        REG_ANGLE_XW = 3'd2,
        REG_ANGLE_YZ = 3'd3,
        REG_ANGLE_YW = 3'd4,
        REG_ANGLE_ZW = 3'd5
    } reg_idx_t;

    // Coordinate order within a vertex: x, y, z, w.
    localparam logic [1:0] PLANE_A [0:NUM_PLANES-1] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] PLANE_B [0:NUM_PLANES-1] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};
    // XW, YW and ZW planes take the sine with the opposite sign.
    localparam logic [NUM_PLANES-1:0] PLANE_TRANS = 6'b110100;

    typedef logic [3:0][15:0] vec_t;

    typedef struct packed {
        logic signed [15:0] c;
        logic signed [15:0] s;
    } trig_t;

    typedef struct packed {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [16:0] z;
        logic               flip;
        logic [2:0]         tag;
    } cord_t;

    function automatic logic signed [16:0] atan_turn(input logic [3:0] step);
        case (step)
            4'd0:    atan_turn = 17'sd8192;
            4'd1:    atan_turn = 17'sd4836;
            4'd2:    atan_turn = 17'sd2555;
            4'd3:    atan_turn = 17'sd1297;
            4'd4:    atan_turn = 17'sd651;
            4'd5:    atan_turn = 17'sd326;
            4'd6:    atan_turn = 17'sd163;
            4'd7:    atan_turn = 17'sd81;
            4'd8:    atan_turn = 17'sd41;
            4'd9:    atan_turn = 17'sd20;
            4'd10:   atan_turn = 17'sd10;
            4'd11:   atan_turn = 17'sd5;
            4'd12:   atan_turn = 17'sd3;
            4'd13:   atan_turn = 17'sd1;
            default: atan_turn = 17'sd0;
        endcase
    endfunction

    // Round Q4.26 to Q3.12 (half up) and clamp to 16 bits.
    function automatic logic signed [15:0] round_sat(input logic signed [31:0] acc);
        logic signed [31:0] sh;
        sh = (acc + 32'sd8192) >>> 14;
        if (sh > 32'sd32767)
            round_sat = 16'sh7fff;
        else if (sh < -32'sd32768)
            round_sat = 16'sh8000;
        else
            round_sat = sh[15:0];
    endfunction

endpackage

// ===== rtl/core/fdr_cordic_cell.sv =====
`timescale 1ns / 1ps

module fdr_cordic_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [3:0]    step,
    input  logic          in_valid,
    input  fdr_pkg::cord_t in_data,
    output logic          out_valid,
    output fdr_pkg::cord_t out_data
);
    import fdr_pkg::*;

    logic  valid_reg;
    cord_t data_reg;
    cord_t data_next;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic signed [16:0] t;

    always_comb
    begin
        dx = in_data.y >>> step;
        dy = in_data.x >>> step;
        t  = atan_turn(step);
        data_next = in_data;
        if (!in_data.z[16])
        begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - t;
        end
        else
        begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/fdr_trig.sv =====
`timescale 1ns / 1ps

module fdr_trig (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output logic                busy,
    output fdr_pkg::trig_t [5:0] trig
);
    import fdr_pkg::*;

    logic [15:0] angle_reg [0:NUM_PLANES-1];
    trig_t       trig_reg  [0:NUM_PLANES-1];
    logic [4:0]  cnt_reg;
    logic [4:0]  cnt_next;
    logic        busy_reg;
    logic        busy_next;

    logic  chain_valid [0:CORDIC_STEPS];
    cord_t chain_data  [0:CORDIC_STEPS];

    logic signed [16:0] a;
    logic signed [15:0] c_clamp;
    logic signed [15:0] s_clamp;
    cord_t tail;
    trig_t post;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
                angle_reg[i] <= 16'd0;
        end
        else if (cfg_we && (cfg_index < 3'(NUM_PLANES)))
        begin
            angle_reg[cfg_index] <= cfg_data;
        end
    end

    // Sweep the six angles through the chain after reset and after every write.
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (cfg_we)
        begin
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(SWEEP_LAST))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 5'd0;
            busy_reg <= 1'b1;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    // Fold the phase into [-quarter, quarter]; negate at the end if folded.
    always_comb
    begin
        a = {angle_reg[cnt_reg[2:0]][15], angle_reg[cnt_reg[2:0]]};
        chain_data[0].x    = CORDIC_START;
        chain_data[0].y    = 18'sd0;
        chain_data[0].flip = 1'b0;
        chain_data[0].tag  = cnt_reg[2:0];
        chain_data[0].z    = a;
        if (a > QUARTER)
        begin
            chain_data[0].z    = a - HALF_TURN;
            chain_data[0].flip = 1'b1;
        end
        else if (a < -QUARTER)
        begin
            chain_data[0].z    = a + HALF_TURN;
            chain_data[0].flip = 1'b1;
        end
        chain_valid[0] = busy_reg && (cnt_reg < 5'(NUM_PLANES));
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        fdr_cordic_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .step     (4'(i)),
            .in_valid (chain_valid[i]),
            .in_data  (chain_data[i]),
            .out_valid(chain_valid[i+1]),
            .out_data (chain_data[i+1])
        );
    end

    always_comb
    begin
        tail = chain_data[CORDIC_STEPS];
        if (tail.x > TRIG_MAX)
            c_clamp = TRIG_MAX[15:0];
        else if (tail.x < TRIG_MIN)
            c_clamp = TRIG_MIN[15:0];
        else
            c_clamp = tail.x[15:0];
        if (tail.y > TRIG_MAX)
            s_clamp = TRIG_MAX[15:0];
        else if (tail.y < TRIG_MIN)
            s_clamp = TRIG_MIN[15:0];
        else
            s_clamp = tail.y[15:0];
        post.c = tail.flip ? -c_clamp : c_clamp;
        post.s = (tail.flip ^ PLANE_TRANS[tail.tag]) ? -s_clamp : s_clamp;
    end

    always_ff @(posedge clk)
    begin
        if (chain_valid[CORDIC_STEPS])
            trig_reg[tail.tag] <= post;
    end

    assign busy = busy_reg;

    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_out
        assign trig[p] = trig_reg[p];
    end

endmodule

// ===== rtl/core/fdr_plane_cell.sv =====
`timescale 1ns / 1ps

module fdr_plane_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [1:0]     idx_a,
    input  logic [1:0]     idx_b,
    input  fdr_pkg::trig_t trig,
    input  logic           in_valid,
    output logic           in_ready,
    input  fdr_pkg::vec_t  in_vec,
    output logic           out_valid,
    input  logic           out_ready,
    output fdr_pkg::vec_t  out_vec
);
    import fdr_pkg::*;

    logic v1_reg;
    logic v2_reg;
    logic ready1;
    logic ready2;
    vec_t vec1_reg;
    vec_t vec2_reg;
    vec_t vec2_next;
    logic signed [31:0] pa_reg;
    logic signed [31:0] pb_reg;
    logic signed [31:0] pc_reg;
    logic signed [31:0] pd_reg;
    logic signed [15:0] a;
    logic signed [15:0] b;

    assign ready2   = !v2_reg || out_ready;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    assign a = $signed(in_vec[idx_a]);
    assign b = $signed(in_vec[idx_b]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                v1_reg <= in_valid;
            if (ready2)
                v2_reg <= v1_reg;
        end
    end

    // Products first, then sum, round and clamp.
    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            vec1_reg <= in_vec;
            pa_reg   <= 32'(trig.c) * 32'(a);
            pb_reg   <= 32'(trig.s) * 32'(b);
            pc_reg   <= 32'(trig.s) * 32'(a);
            pd_reg   <= 32'(trig.c) * 32'(b);
        end
    end

    always_comb
    begin
        vec2_next        = vec1_reg;
        vec2_next[idx_a] = round_sat(pa_reg - pb_reg);
        vec2_next[idx_b] = round_sat(pc_reg + pd_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ready2)
            vec2_reg <= vec2_next;
    end

    assign out_valid = v2_reg;
    assign out_vec   = vec2_reg;

endmodule

// ===== rtl/core/four_d_plane_rotation.sv =====
// An accepted item reaches m_tvalid through six plane cells, each a product
// register and a sum register; the ready chain lets bubbles close up.
// Throughput: one item per cycle unless m_tready is low or a sweep is running.
// Sine and cosine come from a 14-cell CORDIC chain fed one angle a cycle:
// after reset and after each configuration write s_tready stays low while the sweep runs.
// Reset (rst_n, asynchronous, active low) clears all angles to zero and valid flags.
`timescale 1ns / 1ps

module four_d_plane_rotation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // in_x, in_y, in_z, in_w
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // out_x, out_y, out_z, out_w
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import fdr_pkg::*;

    logic              busy;
    trig_t [5:0]       trig;
    logic              st_valid [0:NUM_PLANES];
    logic              st_ready [0:NUM_PLANES];
    vec_t              st_vec   [0:NUM_PLANES];

    fdr_trig u_trig (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .busy     (busy),
        .trig     (trig)
    );

    // Hold the input while the sine/cosine sweep runs.
    assign st_valid[0] = s_tvalid && !busy;
    assign s_tready    = st_ready[0] && !busy;
    assign st_vec[0]   = s_tdata;

    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_plane
        fdr_plane_cell u_plane (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx_a    (PLANE_A[p]),
            .idx_b    (PLANE_B[p]),
            .trig     (trig[p]),
            .in_valid (st_valid[p]),
            .in_ready (st_ready[p]),
            .in_vec   (st_vec[p]),
            .out_valid(st_valid[p+1]),
            .out_ready(st_ready[p+1]),
            .out_vec  (st_vec[p+1])
        );
    end

    assign st_ready[NUM_PLANES] = m_tready;
    assign m_tvalid             = st_valid[NUM_PLANES];
    assign m_tdata              = st_vec[NUM_PLANES];

`ifndef SYNTH
    a_write_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !s_tready)
        else $error("input accepted right after a configuration write");

    a_ready_not_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s_tready) |-> !$past(cfg_we))
        else $error("ready rose straight after a configuration write");
`endif

endmodule

// ===== bench/four_d_plane_rotation_tb.sv =====
`timescale 1ns / 1ps

module four_d_plane_rotation_tb;

    import fdr_pkg::*;

    localparam int          QUIET_LIMIT   = 3000;
    localparam int          HOLD_CYCLES   = 250;
    localparam int          TAIL_CYCLES   = 16;
    localparam int          PHASE_ITEMS   = 150;
    localparam int          RANDOM_PHASES = 8;
    localparam logic [2:0]  REG_SPARE_LO  = 3'd6;
    localparam logic [2:0]  REG_SPARE_HI  = 3'd7;

    class rotation_scoreboard;
        logic [15:0] angle [NUM_PLANES];
        vec_t        expected_vertices [$];
        int          errors;
        int          results_seen;

        function new();
            foreach (angle[i])
                angle[i] = 16'h0000;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] val);
            if (idx < NUM_PLANES)
                angle[idx] = val;
        endfunction

        // Fold the phase into [-quarter, quarter], run the fixed-point CORDIC, unfold.
        function void phase_to_trig(input logic [15:0] phase, output int c, output int s);
            int step_angle [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                    41, 20, 10, 5, 3, 1};
            int a;
            int x;
            int y;
            int z;
            int dx;
            int dy;
            bit flip;
            a    = $signed(phase);
            flip = 1'b0;
            if (a > 16384) begin
                a    = a - 32768;
                flip = 1'b1;
            end
            else if (a < -16384) begin
                a    = a + 32768;
                flip = 1'b1;
            end
            x = 9949;
            y = 0;
            z = a;
            for (int i = 0; i < 14; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - step_angle[i];
                end
                else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + step_angle[i];
                end
            end
            c = (x > 16384) ? 16384 : ((x < -16384) ? -16384 : x);
            s = (y > 16384) ? 16384 : ((y < -16384) ? -16384 : y);
            if (flip) begin
                c = -c;
                s = -s;
            end
        endfunction

        function int dot_round_sat(int p, int u, int q, int v);
            longint acc;
            acc = longint'(p) * longint'(u) + longint'(q) * longint'(v);
            acc = (acc + 64'sd8192) >>> 14;
            if (acc > 32767)
                return 32767;
            if (acc < -32768)
                return -32768;
            return int'(acc);
        endfunction

        function vec_t rotate_vertex(vec_t v);
            int   axis_a [NUM_PLANES] = '{0, 0, 0, 1, 1, 2};
            int   axis_b [NUM_PLANES] = '{1, 2, 3, 2, 3, 3};
            bit   flipped_sine [NUM_PLANES] = '{0, 0, 1, 0, 1, 1};
            int   coord [4];
            int   c;
            int   s;
            int   na;
            int   nb;
            vec_t r;
            for (int i = 0; i < 4; i++)
                coord[i] = $signed(v[i]);
            for (int k = 0; k < NUM_PLANES; k++) begin
                phase_to_trig(angle[k], c, s);
                if (flipped_sine[k])
                    s = -s;
                na = dot_round_sat(c, coord[axis_a[k]], -s, coord[axis_b[k]]);
                nb = dot_round_sat(s, coord[axis_a[k]], c, coord[axis_b[k]]);
                coord[axis_a[k]] = na;
                coord[axis_b[k]] = nb;
            end
            for (int i = 0; i < 4; i++)
                r[i] = coord[i][15:0];
            return r;
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void note_vertex(vec_t v);
            expected_vertices.insert(expected_vertices.size(), rotate_vertex(v));
        endfunction

        task check_vertex(vec_t got);
            vec_t     exp_v;
            bit [3:0] bad;
            results_seen++;
            if (expected_vertices.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          results_seen));
                return;
            end
            exp_v = expected_vertices.pop_front();
            bad   = 4'b0000;
            for (int i = 0; i < 4; i++)
                if (got[i] !== exp_v[i])
                    bad[i] = 1'b1;
            if (bad != 4'b0000)
                report_mismatch($sformatf(
                    "result %0d fields(wzyx)=%b got %0d %0d %0d %0d exp %0d %0d %0d %0d",
                    results_seen, bad,
                    $signed(got[0]), $signed(got[1]), $signed(got[2]), $signed(got[3]),
                    $signed(exp_v[0]), $signed(exp_v[1]), $signed(exp_v[2]),
                    $signed(exp_v[3])));
        endtask

        task check_leftovers();
            if (expected_vertices.size() != 0)
                report_mismatch($sformatf("%0d results never arrived",
                                          expected_vertices.size()));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    rotation_scoreboard sb = new();
    bit                 no_idle   = 1'b0;
    bit                 hold_out  = 1'b0;

    four_d_plane_rotation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic vec_t make_vertex(logic [15:0] x, logic [15:0] y,
                                         logic [15:0] z, logic [15:0] w);
        return {w, z, y, x};
    endfunction

    function automatic logic [15:0] random_coord(int mode);
        logic [15:0] corners [5] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h1000};
        case (mode)
            0, 1, 2, 3, 4: return 16'($urandom);
            5, 6:          return 16'($urandom_range(8192) - 4096);
            7:             return corners[$urandom_range(4)];
            default:       return ($urandom_range(1) == 0) ? 16'($urandom) :
                                  corners[$urandom_range(4)];
        endcase
    endfunction

    function automatic vec_t random_vertex();
        int mode;
        mode = $urandom_range(9);
        return make_vertex(random_coord(mode), random_coord(mode),
                           random_coord(mode), random_coord(mode));
    endfunction

    function automatic logic [15:0] random_angle();
        logic [15:0] corners [8] = '{16'h0000, 16'h3fff, 16'h4000, 16'h4001,
                                     16'h8000, 16'hbfff, 16'hc000, 16'hffff};
        if ($urandom_range(3) == 0)
            return corners[$urandom_range(7)];
        return 16'($urandom);
    endfunction

    // Write all six angles, then one spare index that must leave them alone.
    task automatic set_angles(input logic [15:0] ang [NUM_PLANES]);
        reg_idx_t    idx;
        logic [2:0]  spare;
        logic [15:0] junk;
        idx = idx.first();
        repeat (NUM_PLANES) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= ang[idx];
            sb.write_reg(idx, ang[idx]);
            @(posedge clk);
            idx = idx.next();
        end
        spare     = ($urandom_range(1) == 0) ? REG_SPARE_LO : REG_SPARE_HI;
        junk      = 16'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= spare;
        cfg_data  <= junk;
        sb.write_reg(spare, junk);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_vertex(input vec_t v);
        while (!no_idle && $urandom_range(99) < 31) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_vertex(v);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (sb.expected_vertices.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic run_directed();
        vec_t probes [8];
        probes[0] = make_vertex(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        probes[1] = make_vertex(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        probes[2] = make_vertex(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        probes[3] = make_vertex(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        probes[4] = make_vertex(16'h1000, 16'h0000, 16'h0000, 16'h0000);
        probes[5] = make_vertex(16'h0000, 16'h1000, 16'h0000, 16'h0000);
        probes[6] = make_vertex(16'h0000, 16'h0000, 16'hf000, 16'h0000);
        probes[7] = make_vertex(16'h0000, 16'h0000, 16'h0000, 16'hffff);
        foreach (probes[i])
            send_vertex(probes[i]);
        wait_drain();
    endtask

    task automatic run_random_phase();
        logic [15:0] ang [NUM_PLANES];
        foreach (ang[i])
            ang[i] = random_angle();
        set_angles(ang);
        repeat (PHASE_ITEMS)
            send_vertex(random_vertex());
        wait_drain();
    endtask

    initial
    begin
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_out) begin
                // Hold off long enough for the pipeline to fill and stall the input.
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_out = 1'b0;
            end
            else
                m_tready <= no_idle || ($urandom_range(99) >= 31);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_vertex(m_tdata);
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        logic [15:0] quarter_turns [NUM_PLANES];
        logic [15:0] eighth_turns  [NUM_PLANES];
        quarter_turns = '{16'h4000, 16'h8000, 16'hc000, 16'h4001, 16'hbfff, 16'hffff};
        eighth_turns  = '{16'h2000, 16'h2000, 16'he000, 16'h2000, 16'h6000, 16'ha000};
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_ANGLE_XY;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset angles first, then folded phases, then saturating eighth turns.
        run_directed();
        set_angles(quarter_turns);
        run_directed();
        set_angles(eighth_turns);
        run_directed();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            no_idle  = (p == 2);
            hold_out = (p == 4);
            run_random_phase();
        end
        no_idle = 1'b0;

        sb.check_leftovers();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== four_d_plane_rotation.f =====
rtl/core/fdr_pkg.sv
rtl/core/fdr_cordic_cell.sv
rtl/core/fdr_trig.sv
rtl/core/fdr_plane_cell.sv
rtl/core/four_d_plane_rotation.sv
bench/four_d_plane_rotation_tb.sv
